@@ hw/rtl/ipc_heartbeat_scheduler_assert.svh @@
// Assertion macros for the checker module of the heartbeat scheduler.
`ifndef IPC_HEARTBEAT_SCHEDULER_ASSERT_SVH
`define IPC_HEARTBEAT_SCHEDULER_ASSERT_SVH

// Property checked at every clock edge, switched off while reset is high.
`define IPCHB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Property checked at every clock edge, including the reset cycles.
`define IPCHB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/ipchb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ipchb_pkg;

   // Width of the wrapping tick counter and of the deadline.
   localparam int TimeBits = 32;
   localparam int RegBits  = 20;
   localparam int CntBits  = 32;

   // Acknowledgement state that marks a finished request.
   localparam logic [7:0] AckComplete = 8'd2;

   // Reset values of the configuration registers.
   localparam logic [RegBits-1:0] HbIntervalReset = 20'd200;
   localparam logic [RegBits-1:0] RetryDelayReset = 20'd10;

   typedef logic [TimeBits-1:0] time_type;
   typedef logic [CntBits-1:0]  count_type;
   typedef logic [RegBits-1:0]  reg_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_HB_INTERVAL = 1'b0,
      CSR_RETRY_DELAY = 1'b1
   } csr_index_type;

   // Item operation codes.
   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_POWER_UP = 2'd1,
      OP_HB_DONE  = 2'd2
   } op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BUSY      = 3'd1,
      ST_BAD_ACK   = 3'd2,
      ST_TRANSPORT = 3'd3,
      ST_REJECTED  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       transport_ok;
      logic       ack_present;
      logic [7:0] ack_state;
      logic       mailbox_accepts;
   } req_type;

   typedef struct packed {
      logic       send_heartbeat;
      logic       armed;
      logic       send_pending;
      logic [2:0] status_code;
      logic       failure_report;
      count_type  failure_count;
      count_type  submission_count;
      count_type  completion_count;
   } rsp_type;

   // Judges a completion: the transport must succeed and the acknowledgement
   // must be present and report completion.
   function automatic status_type judge(input req_type item);
      status_type res;
      if (!item.transport_ok) begin
         res = ST_TRANSPORT;
      end else if (!item.ack_present || item.ack_state != AckComplete) begin
         res = ST_BAD_ACK;
      end else begin
         res = ST_OK;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ipc_heartbeat_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Heartbeat scheduler for an inter-processor link.
// Items arrive on the req_ channel (valid/ready): a tick, a power-up
// completion or a heartbeat completion. Every item gives exactly one result
// on the rsp_ channel, showing the scheduler state after that item and
// whether a heartbeat send was issued.
// An accepted item is held in an input register, evaluated by a single
// compare-and-increment stage against the state registers, and its result
// is loaded into the output register as the item moves on; rsp_valid rises
// as the result is loaded.
// Throughput is one item per cycle while results are taken; the output register
// takes a new result whenever it is empty or its result is being taken.
// When the receiver stalls, the output register holds its result and the
// input register keeps one more item; req_ready falls only when both are
// full and rsp_ready is low.
// Synchronous reset clears time, deadline, flags and counters, empties both
// registers and restores the interval to 200 and the retry delay to 10 ticks.
// Configuration writes on the csr_ port take effect at once and are meant
// to be made while no item is in flight.
module ipc_heartbeat_scheduler (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire ipchb_pkg::req_type        req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output ipchb_pkg::rsp_type             rsp_data,
   input  wire logic                      csr_write_en,
   input  wire ipchb_pkg::csr_index_type  csr_index,
   input  wire ipchb_pkg::reg_type        csr_wdata
);

   // Handshake and pipeline control.
   logic                  in_vld_ff;
   ipchb_pkg::req_type    in_ff;
   logic                  out_vld_ff;
   ipchb_pkg::rsp_type    out_ff;
   logic                  advance;

   // Configuration registers.
   ipchb_pkg::reg_type    hb_interval_ff;
   ipchb_pkg::reg_type    retry_delay_ff;

   // Scheduler state and its next values.
   ipchb_pkg::time_type   tick_ff, tick_in;
   ipchb_pkg::time_type   deadline_ff, deadline_in;
   logic                  enabled_ff, enabled_in;
   logic                  pending_ff, pending_in;
   ipchb_pkg::status_type last_result_ff, last_result_in;
   ipchb_pkg::count_type  failures_ff, failures_in;
   ipchb_pkg::count_type  submissions_ff, submissions_in;
   ipchb_pkg::count_type  completions_ff, completions_in;

   // Per-item evaluation signals.
   ipchb_pkg::time_type   tick_next;
   ipchb_pkg::time_type   due_diff;
   ipchb_pkg::count_type  fail_inc;
   logic                  sent;
   logic                  report;
   ipchb_pkg::rsp_type    out_in;

   // The held item moves on when the output register is free or draining.
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hb_interval_ff <= ipchb_pkg::HbIntervalReset;
         retry_delay_ff <= ipchb_pkg::RetryDelayReset;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ipchb_pkg::CSR_HB_INTERVAL: hb_interval_ff <= csr_wdata;
            ipchb_pkg::CSR_RETRY_DELAY: retry_delay_ff <= csr_wdata;
         endcase
      end
   end

   // Evaluation of the held item against the current state.
   always_comb begin
      tick_in        = tick_ff;
      deadline_in    = deadline_ff;
      enabled_in     = enabled_ff;
      pending_in     = pending_ff;
      last_result_in = last_result_ff;
      failures_in    = failures_ff;
      submissions_in = submissions_ff;
      completions_in = completions_ff;
      sent           = 1'b0;
      report         = 1'b0;

      tick_next = tick_ff + ipchb_pkg::time_type'(1);
      due_diff  = tick_next - deadline_ff;
      fail_inc  = failures_ff + ipchb_pkg::count_type'(1);

      unique case (in_ff.operation)
         ipchb_pkg::OP_TICK: begin
            tick_in = tick_next;
            // The poll runs only while armed and with no send outstanding.
            if (enabled_ff && !pending_ff) begin
               if (last_result_ff != ipchb_pkg::ST_OK) begin
                  failures_in    = fail_inc;
                  report         = (fail_inc & (fail_inc - ipchb_pkg::count_type'(1)))
                                   == '0;
                  last_result_in = ipchb_pkg::ST_OK;
               end
               // Due once the signed distance to the deadline is not negative.
               if (!due_diff[ipchb_pkg::TimeBits-1]) begin
                  if (in_ff.mailbox_accepts) begin
                     sent           = 1'b1;
                     pending_in     = 1'b1;
                     last_result_in = ipchb_pkg::ST_BUSY;
                     submissions_in = submissions_ff + ipchb_pkg::count_type'(1);
                     deadline_in    = tick_next + ipchb_pkg::time_type'(hb_interval_ff);
                  end else begin
                     last_result_in = ipchb_pkg::ST_REJECTED;
                     deadline_in    = tick_next + ipchb_pkg::time_type'(retry_delay_ff);
                  end
               end
            end
         end
         ipchb_pkg::OP_POWER_UP: begin
            if (ipchb_pkg::judge(in_ff) == ipchb_pkg::ST_OK) begin
               last_result_in = ipchb_pkg::ST_OK;
               deadline_in    = tick_ff + ipchb_pkg::time_type'(hb_interval_ff);
               enabled_in     = 1'b1;
            end
         end
         ipchb_pkg::OP_HB_DONE: begin
            last_result_in = ipchb_pkg::judge(in_ff);
            completions_in = completions_ff + ipchb_pkg::count_type'(1);
            pending_in     = 1'b0;
         end
         default: begin
            // Unused operation code: state is left as it is.
         end
      endcase

      out_in.send_heartbeat   = sent;
      out_in.armed            = enabled_in;
      out_in.send_pending     = pending_in;
      out_in.status_code      = last_result_in;
      out_in.failure_report   = report;
      out_in.failure_count    = failures_in;
      out_in.submission_count = submissions_in;
      out_in.completion_count = completions_in;
   end

   // State registers, updated as each item moves to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= '0;
         deadline_ff    <= '0;
         enabled_ff     <= 1'b0;
         pending_ff     <= 1'b0;
         last_result_ff <= ipchb_pkg::ST_OK;
         failures_ff    <= '0;
         submissions_ff <= '0;
         completions_ff <= '0;
      end else if (advance) begin
         tick_ff        <= tick_in;
         deadline_ff    <= deadline_in;
         enabled_ff     <= enabled_in;
         pending_ff     <= pending_in;
         last_result_ff <= last_result_in;
         failures_ff    <= failures_in;
         submissions_ff <= submissions_in;
         completions_ff <= completions_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ipchb_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "ipc_heartbeat_scheduler_assert.svh"

module ipchb_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire ipchb_pkg::rsp_type        rsp_data
);

   // Conditions on the result port, named to keep the assertions short.
   logic rsp_stalled;
   logic send_issued;
   logic send_state_ok;
   logic report_seen;
   logic one_bit_count;

   assign rsp_stalled   = rsp_valid && !rsp_ready;
   assign send_issued   = rsp_valid && rsp_data.send_heartbeat;
   assign send_state_ok = rsp_data.armed && rsp_data.send_pending
                          && rsp_data.status_code == ipchb_pkg::ST_BUSY;
   assign report_seen   = rsp_valid && rsp_data.failure_report;
   assign one_bit_count = $countones(rsp_data.failure_count) <= 1;

   // No result is shown in the cycle after a reset.
   `IPCHB_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid)

   // A stalled result stays on the port unchanged.
   `IPCHB_ASSERT(a_rsp_held, clock, reset, rsp_stalled |=> rsp_valid && $stable(rsp_data))

   // An issued heartbeat leaves the scheduler armed with a send outstanding.
   `IPCHB_ASSERT(a_send_state, clock, reset, send_issued |-> send_state_ok)

   // A failure report only fires on a power-of-two (or wrapped) count.
   `IPCHB_ASSERT(a_report_pow2, clock, reset, report_seen |-> one_bit_count)

endmodule

bind ipc_heartbeat_scheduler ipchb_checker u_ipchb_checker (.*);

`default_nettype wire

@@ tb/sv/ipc_heartbeat_scheduler_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the heartbeat scheduler, predicts the result of
// every accepted item and compares it with what comes out, in order.
module ipc_heartbeat_scheduler_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  ipchb_pkg::req_type        req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  ipchb_pkg::rsp_type        rsp_data,
   input  logic                      csr_write_en,
   input  ipchb_pkg::csr_index_type  csr_index,
   input  ipchb_pkg::reg_type        csr_wdata,
   output int                        mismatch_count,
   output int                        outstanding
);

   import ipchb_pkg::*;

   // Own copy of the configuration and of the scheduler state.
   reg_type    hb_interval;
   reg_type    retry_delay;
   time_type   now_tick;
   time_type   due_tick;
   logic       armed_q;
   logic       pending_q;
   status_type status_q;
   count_type  failure_total;
   count_type  submission_total;
   count_type  completion_total;

   rsp_type    expected_rsps[$];
   int         errors = 0;

   // A completion is good only with a working transport and a complete ack.
   function automatic status_type completion_verdict(input req_type item);
      if (!item.transport_ok) begin
         return ST_TRANSPORT;
      end
      if (!item.ack_present || item.ack_state != AckComplete) begin
         return ST_BAD_ACK;
      end
      return ST_OK;
   endfunction

   // Applies one item to the predicted state and returns the result it gives.
   function automatic rsp_type advance_scheduler(input req_type item);
      rsp_type    res;
      logic       sent;
      logic       report;
      time_type   gap;
      status_type verdict;
      sent = 1'b0;
      report = 1'b0;
      verdict = completion_verdict(item);
      case (item.operation)
         OP_TICK: begin
            now_tick = now_tick + 1'b1;
            // The poll only runs while armed and with no send in flight.
            if (armed_q && !pending_q) begin
               if (status_q != ST_OK) begin
                  failure_total = failure_total + 1'b1;
                  report = ((failure_total & (failure_total - 1'b1)) == '0);
                  status_q = ST_OK;
               end
               // The deadline is due once the wrapped difference is not negative.
               gap = now_tick - due_tick;
               if (!gap[TimeBits-1]) begin
                  if (item.mailbox_accepts) begin
                     sent = 1'b1;
                     pending_q = 1'b1;
                     status_q = ST_BUSY;
                     submission_total = submission_total + 1'b1;
                     due_tick = now_tick + time_type'(hb_interval);
                  end else begin
                     status_q = ST_REJECTED;
                     due_tick = now_tick + time_type'(retry_delay);
                  end
               end
            end
         end
         OP_POWER_UP: begin
            // Only a good power-up arms the heartbeat; a bad one changes nothing.
            if (verdict == ST_OK) begin
               status_q = ST_OK;
               due_tick = now_tick + time_type'(hb_interval);
               armed_q = 1'b1;
            end
         end
         OP_HB_DONE: begin
            status_q = verdict;
            completion_total = completion_total + 1'b1;
            pending_q = 1'b0;
         end
         default: begin
            // The unused operation code leaves the state alone.
         end
      endcase
      res.send_heartbeat   = sent;
      res.armed            = armed_q;
      res.send_pending     = pending_q;
      res.status_code      = status_q;
      res.failure_report   = report;
      res.failure_count    = failure_total;
      res.submission_count = submission_total;
      res.completion_count = completion_total;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // Everything is sampled at the rising edge, before any input moves.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         hb_interval      = HbIntervalReset;
         retry_delay      = RetryDelayReset;
         now_tick         = '0;
         due_tick         = '0;
         armed_q          = 1'b0;
         pending_q        = 1'b0;
         status_q         = ST_OK;
         failure_total    = '0;
         submission_total = '0;
         completion_total = '0;
         expected_rsps.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_HB_INTERVAL: hb_interval = csr_wdata;
               CSR_RETRY_DELAY: retry_delay = csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            expected_rsps.push_back(advance_scheduler(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_rsps.size() == 0) begin
               $error("result arrived with no item waiting for one");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("send_heartbeat", want.send_heartbeat, got.send_heartbeat);
               check_field("armed", want.armed, got.armed);
               check_field("send_pending", want.send_pending, got.send_pending);
               check_field("status_code", want.status_code, got.status_code);
               check_field("failure_report", want.failure_report, got.failure_report);
               check_field("failure_count", want.failure_count, got.failure_count);
               check_field("submission_count", want.submission_count,
                           got.submission_count);
               check_field("completion_count", want.completion_count,
                           got.completion_count);
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= expected_rsps.size();
   end

endmodule

@@ tb/sv/ipc_heartbeat_scheduler_tb.sv @@
`timescale 1ns / 1ps

module ipc_heartbeat_scheduler_tb;

   import ipchb_pkg::*;

   // Operation code with no meaning to the block.
   localparam logic [1:0] OpUnused   = 2'd3;
   localparam int         StallLimit = 2000;
   localparam int         PhaseCount = 6;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_data;
   logic          csr_write_en;
   csr_index_type csr_index;
   reg_type       csr_wdata;

   int            mismatch_count;
   int            outstanding;
   int            send_idle_pct;
   int            rcv_idle_pct;
   int            stall_cycles;

   // Settings of the random phases: small intervals keep heartbeats frequent,
   // zero and the largest values cover the extremes.
   reg_type       phase_interval [PhaseCount] = '{20'd3, 20'd1, 20'd7, 20'd0,
                                                  20'd1000000, 20'hFFFFF};
   reg_type       phase_retry    [PhaseCount] = '{20'd1, 20'd5, 20'd2, 20'd3,
                                                  20'd1000000, 20'd1};
   int            phase_items    [PhaseCount] = '{520, 420, 400, 240, 50, 40};

   ipc_heartbeat_scheduler dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   ipc_heartbeat_scheduler_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic req_type make_req(input logic [1:0] op, input logic tok,
                                        input logic ack, input logic [7:0] state,
                                        input logic accepts);
      req_type item;
      item.operation       = op;
      item.transport_ok    = tok;
      item.ack_present     = ack;
      item.ack_state       = state;
      item.mailbox_accepts = accepts;
      return item;
   endfunction

   // Mostly ticks, with enough good completions to keep heartbeats flowing;
   // the rest is bad completions and the unused operation code.
   function automatic req_type random_heartbeat_item();
      req_type item;
      int      pick;
      pick = $urandom_range(99);
      item.transport_ok    = 1'($urandom_range(1));
      item.ack_present     = 1'($urandom_range(1));
      item.ack_state       = 8'($urandom_range(255));
      item.mailbox_accepts = ($urandom_range(99) < 75);
      if (pick < 68) begin
         item.operation = OP_TICK;
      end else if (pick < 96) begin
         item.operation = (pick < 74) ? OP_POWER_UP : OP_HB_DONE;
         if ($urandom_range(9) < 7) begin
            item.transport_ok = 1'b1;
            item.ack_present  = 1'b1;
            item.ack_state    = AckComplete;
         end
      end else begin
         item.operation = OpUnused;
      end
      return item;
   endfunction

   // Offers one item, with random gaps before it, and returns once taken.
   task automatic push_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Lets every expected result come out before the block is reconfigured.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input reg_type interval, input reg_type retry);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_HB_INTERVAL;
      csr_wdata    <= interval;
      @(posedge clock);
      csr_index    <= CSR_RETRY_DELAY;
      csr_wdata    <= retry;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Receiver: random stalls, plus a long hold-off now and then so that the
   // block fills up and has to stop taking items.
   initial begin : receiver
      int taken;
      int hold_left;
      taken = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            taken++;
            if (taken % 500 == 250) begin
               hold_left = 48;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Watchdog: too long without any item moving ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int done;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_HB_INTERVAL;
      csr_wdata     = '0;
      send_idle_pct = 28;
      rcv_idle_pct  = 52;
      done          = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with zero interval and retry, so every poll is due.
      write_settings(20'd0, 20'd0);
      push_item(make_req(OP_TICK, 1'b1, 1'b1, 8'hFF, 1'b1));      // disarmed tick
      push_item(make_req(OP_POWER_UP, 1'b0, 1'b1, AckComplete, 1'b1));
      push_item(make_req(OP_POWER_UP, 1'b1, 1'b0, AckComplete, 1'b0));
      push_item(make_req(OP_POWER_UP, 1'b1, 1'b1, 8'hFF, 1'b0));
      push_item(make_req(OpUnused, 1'b1, 1'b1, 8'hFF, 1'b1));
      push_item(make_req(OP_POWER_UP, 1'b1, 1'b1, AckComplete, 1'b0));
      push_item(make_req(OP_TICK, 1'b0, 1'b0, 8'h00, 1'b0));      // rejected
      push_item(make_req(OP_TICK, 1'b0, 1'b0, 8'h00, 1'b1));      // counted, sent
      push_item(make_req(OP_TICK, 1'b1, 1'b1, 8'hFF, 1'b1));      // still pending
      push_item(make_req(OP_HB_DONE, 1'b0, 1'b1, AckComplete, 1'b0));
      push_item(make_req(OP_TICK, 1'b0, 1'b0, 8'h00, 1'b1));
      push_item(make_req(OP_HB_DONE, 1'b1, 1'b1, 8'h00, 1'b0));
      push_item(make_req(OP_TICK, 1'b1, 1'b0, 8'h80, 1'b0));
      push_item(make_req(OP_TICK, 1'b0, 1'b1, 8'h7F, 1'b1));
      push_item(make_req(OP_HB_DONE, 1'b1, 1'b1, AckComplete, 1'b1));
      push_item(make_req(OP_HB_DONE, 1'b1, 1'b1, AckComplete, 1'b0)); // not pending
      push_item(make_req(OP_TICK, 1'b0, 1'b0, 8'h00, 1'b1));
      push_item(make_req(OP_HB_DONE, 1'b1, 1'b0, 8'hFF, 1'b1));
      push_item(make_req(OP_POWER_UP, 1'b1, 1'b1, AckComplete, 1'b1)); // re-arm
      push_item(make_req(OP_TICK, 1'b1, 1'b1, 8'hFF, 1'b1));
      settle();

      // Random part, one phase per setting; idling shifts with progress.
      for (int p = 0; p < PhaseCount; p++) begin
         write_settings(phase_interval[p], phase_retry[p]);
         for (int n = 0; n < phase_items[p]; n++) begin
            if (done < 560) begin
               send_idle_pct = 28;
               rcv_idle_pct  = 52;
            end else if (done < 1120) begin
               send_idle_pct = 52;
               rcv_idle_pct  = 28;
            end else begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
            push_item(random_heartbeat_item());
            done++;
         end
         settle();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ipchb_pkg.sv
hw/rtl/ipc_heartbeat_scheduler.sv
hw/rtl/ipchb_checker.sv
tb/sv/ipc_heartbeat_scheduler_checker.sv
tb/sv/ipc_heartbeat_scheduler_tb.sv
